// ===== src/esd_pkg.sv =====
// Package: types, character codes and helpers for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

   localparam int unsigned MaxResults = 4;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_end;
   } esd_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_end;
   } esd_rsp_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_OCT  = 3'd2,
      MODE_HEX1 = 3'd3,
      MODE_HEX2 = 3'd4
   } parse_mode_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_V      = 8'h76;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_X      = 8'h78;

   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_HT  = 8'd9;
   localparam logic [7:0] CODE_VT  = 8'd11;
   localparam logic [7:0] CODE_BEL = 8'd7;

   function automatic logic is_oct(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h37);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Nibble value of a hex digit; zero for anything else.
   function automatic logic [3:0] hex_nib(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c[3:0];
      end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/escape_sequence_decoder_top.sv =====
// Top level: backslash escape decoder with a four-entry result queue.
//
//  channel | direction | payload          | handshake
//  req_    | in        | esd_req_type     | req_valid / req_stall
//  rsp_    | out       | esd_rsp_type     | rsp_valid / rsp_stall
//
// Each accepted byte is decoded combinationally; its zero to four result
// bytes are loaded into the result queue at the same edge and leave one per
// cycle while rsp_stall is low. A byte with at most one result then sustains one
// transfer per cycle; one with more results stalls req_ while the queue drains.
// req_stall is high while the queue holds more than the one entry leaving now.
// Synchronous reset returns the parser to idle and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_top import esd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire esd_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output esd_rsp_type      rsp_payload
);

   // parser state
   parse_mode_type mode_ff, mode_in;
   logic [7:0]     digit_ff, digit_in;
   logic [1:0]     count_ff, count_in;
   logic [7:0]     held_ff, held_in;

   // result queue, entry 0 is the head
   esd_rsp_type    queue_ff [MaxResults];
   esd_rsp_type    queue_in [MaxResults];
   logic [2:0]     fill_ff, fill_in;

   // state after the byte, before any end-of-string flush
   parse_mode_type step_mode;
   logic [7:0]     step_digit;
   logic [7:0]     step_held;

   esd_rsp_type    emit [MaxResults];
   logic [2:0]     emit_n;

   logic           accept;
   logic           take;
   logic [7:0]     c;
   logic           take_oct;

   assign c        = req_payload.in_char;
   assign take_oct = is_oct(c) &&
                     ((count_ff == 2'd1) || ((count_ff == 2'd2) && (digit_ff < 8'd32)));

   assign rsp_valid   = (fill_ff != 3'd0);
   assign rsp_payload = queue_ff[0];
   assign take        = rsp_valid && !rsp_stall;
   // Accept when the queue is empty or its last entry leaves this cycle.
   assign req_stall   = !((fill_ff == 3'd0) || ((fill_ff == 3'd1) && !rsp_stall));
   assign accept      = req_valid && !req_stall;

   // Next parser state.
   always_comb begin
      step_mode  = mode_ff;
      step_digit = digit_ff;
      step_held  = held_ff;
      count_in   = count_ff;
      case (mode_ff)
         MODE_ESC: begin
            if (c == CHAR_X) begin
               step_mode = MODE_HEX1;
            end else if ((c != CHAR_BSLASH) && is_oct(c)) begin
               step_digit = {5'd0, c[2:0]};
               count_in   = 2'd1;
               step_mode  = MODE_OCT;
            end else begin
               step_mode = MODE_IDLE;
            end
         end
         MODE_OCT: begin
            if (take_oct) begin
               if (count_ff == 2'd2) begin
                  step_digit = 8'd0;
                  count_in   = 2'd0;
                  step_mode  = MODE_IDLE;
               end else begin
                  step_digit = {digit_ff[4:0], c[2:0]};
                  count_in   = count_ff + 2'd1;
               end
            end else begin
               step_digit = 8'd0;
               count_in   = 2'd0;
               step_mode  = (c == CHAR_BSLASH) ? MODE_ESC : MODE_IDLE;
            end
         end
         MODE_HEX1: begin
            if (is_hex(c)) begin
               step_held = c;
               step_mode = MODE_HEX2;
            end else begin
               step_mode = (c == CHAR_BSLASH) ? MODE_ESC : MODE_IDLE;
            end
         end
         MODE_HEX2: begin
            step_held = 8'd0;
            if (is_hex(c)) begin
               step_mode = MODE_IDLE;
            end else begin
               step_mode = (c == CHAR_BSLASH) ? MODE_ESC : MODE_IDLE;
            end
         end
         default: begin
            step_mode = (c == CHAR_BSLASH) ? MODE_ESC : MODE_IDLE;
         end
      endcase

      // End of string: drop anything pending and return to idle.
      if (req_payload.in_end) begin
         mode_in  = MODE_IDLE;
         digit_in = 8'd0;
         held_in  = 8'd0;
         count_in = 2'd0;
      end else begin
         mode_in  = step_mode;
         digit_in = step_digit;
         held_in  = step_held;
      end
   end

   // Result bytes made by the accepted byte.
   always_comb begin
      logic       plain_out;
      logic [2:0] last;
      for (int i = 0; i < MaxResults; i++) begin
         emit[i] = '{out_char: 8'd0, out_end: 1'b0};
      end
      emit_n    = 3'd0;
      plain_out = 1'b0;
      last      = 3'd0;
      case (mode_ff)
         MODE_ESC: begin
            if (c == CHAR_BSLASH) begin
               emit[0].out_char = CHAR_BSLASH;
               emit_n = 3'd1;
            end else if (c == CHAR_R) begin
               emit[0].out_char = CODE_CR;
               emit_n = 3'd1;
            end else if (c == CHAR_N) begin
               emit[0].out_char = CODE_LF;
               emit_n = 3'd1;
            end else if (c == CHAR_T) begin
               emit[0].out_char = CODE_HT;
               emit_n = 3'd1;
            end else if (c == CHAR_V) begin
               emit[0].out_char = CODE_VT;
               emit_n = 3'd1;
            end else if (c == CHAR_A) begin
               emit[0].out_char = CODE_BEL;
               emit_n = 3'd1;
            end else if ((c != CHAR_X) && !is_oct(c)) begin
               // unknown escape: pass both bytes through
               emit[0].out_char = CHAR_BSLASH;
               emit[1].out_char = c;
               emit_n = 3'd2;
            end
         end
         MODE_OCT: begin
            if (take_oct) begin
               if (count_ff == 2'd2) begin
                  emit[0].out_char = {digit_ff[4:0], c[2:0]};
                  emit_n = 3'd1;
               end
            end else begin
               emit[0].out_char = digit_ff;
               emit_n    = 3'd1;
               plain_out = 1'b1;
            end
         end
         MODE_HEX1: begin
            if (!is_hex(c)) begin
               emit[0].out_char = CHAR_BSLASH;
               emit[1].out_char = CHAR_X;
               emit_n    = 3'd2;
               plain_out = 1'b1;
            end
         end
         MODE_HEX2: begin
            if (is_hex(c)) begin
               emit[0].out_char = {hex_nib(held_ff), hex_nib(c)};
               emit_n = 3'd1;
            end else begin
               emit[0].out_char = CHAR_BSLASH;
               emit[1].out_char = CHAR_X;
               emit[2].out_char = held_ff;
               emit_n    = 3'd3;
               plain_out = 1'b1;
            end
         end
         default: begin
            plain_out = 1'b1;
         end
      endcase

      // ordinary byte handling after a fallback or in idle
      if (plain_out && (c != CHAR_BSLASH)) begin
         emit[emit_n[1:0]].out_char = c;
         emit_n = emit_n + 3'd1;
      end

      // flush a pending escape at end of string
      if (req_payload.in_end) begin
         case (step_mode)
            MODE_ESC: begin
               emit[emit_n[1:0]].out_char = CHAR_BSLASH;
               emit_n = emit_n + 3'd1;
            end
            MODE_OCT: begin
               emit[emit_n[1:0]].out_char = step_digit;
               emit_n = emit_n + 3'd1;
            end
            MODE_HEX1: begin
               emit[emit_n[1:0]].out_char = CHAR_BSLASH;
               emit_n = emit_n + 3'd1;
               emit[emit_n[1:0]].out_char = CHAR_X;
               emit_n = emit_n + 3'd1;
            end
            MODE_HEX2: begin
               emit[emit_n[1:0]].out_char = CHAR_BSLASH;
               emit_n = emit_n + 3'd1;
               emit[emit_n[1:0]].out_char = CHAR_X;
               emit_n = emit_n + 3'd1;
               emit[emit_n[1:0]].out_char = step_held;
               emit_n = emit_n + 3'd1;
            end
            default: begin
            end
         endcase
         // mark the last byte of the string
         if (emit_n != 3'd0) begin
            last = emit_n - 3'd1;
            emit[last[1:0]].out_end = 1'b1;
         end
      end
   end

   // Result queue: load on accept, otherwise advance on each output transfer.
   always_comb begin
      for (int i = 0; i < MaxResults; i++) begin
         queue_in[i] = queue_ff[i];
      end
      fill_in = fill_ff;
      if (accept) begin
         for (int i = 0; i < MaxResults; i++) begin
            queue_in[i] = emit[i];
         end
         fill_in = emit_n;
      end else if (take) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         fill_in = fill_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         digit_ff <= 8'd0;
         count_ff <= 2'd0;
         held_ff  <= 8'd0;
         fill_ff  <= 3'd0;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            mode_ff  <= mode_in;
            digit_ff <= digit_in;
            count_ff <= count_in;
            held_ff  <= held_in;
         end
      end
   end

   // payload entries carry no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxResults; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== src/esd_checker.sv =====
// Checker: port-level assertions for the escape sequence decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module esd_checker import esd_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire esd_req_type req_payload,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire esd_rsp_type rsp_payload
);

   // hold a stalled result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // input stalls only while results are waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // the final byte of a string always yields at least one result
   a_end_yields_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.in_end |=> rsp_valid)
      else $error("end of string produced no result");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind escape_sequence_decoder_top esd_checker u_esd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the escape sequence decoder: directed and random byte streams, checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import esd_pkg::*;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel, driven at the rising edge with nonblocking assignments
   logic        req_valid   = 1'b0;
   logic        req_stall;
   esd_req_type req_payload = '0;

   // Result channel
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   esd_rsp_type rsp_payload;

   // Idling control, in percent of cycles
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Bookkeeping
   int          mismatch_count = 0;
   int          bytes_sent     = 0;
   esd_rsp_type expected_bytes[$];
   esd_rsp_type next_expected;

   // Predictor state: a private copy of the decoder's parse state
   parse_mode_type dec_mode    = MODE_IDLE;
   logic [7:0]     dec_octal   = 8'd0;
   logic [1:0]     dec_ndigits = 2'd0;
   logic [7:0]     dec_held    = 8'd0;
   logic [7:0]     step_bytes[$];

   // Escape letters with a fixed meaning, backslash among them
   logic [7:0] named_chars[6] = '{CHAR_R, CHAR_N, CHAR_T, CHAR_V, CHAR_A, CHAR_BSLASH};

   escape_sequence_decoder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Nibble value of a hex digit in either case; -1 for any other byte.
   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   // Handle a byte as in idle: a backslash opens an escape, anything else goes out.
   function automatic void take_plain(input logic [7:0] c);
      if (c == CHAR_BSLASH) begin
         dec_mode = MODE_ESC;
      end else begin
         step_bytes.push_back(c);
         dec_mode = MODE_IDLE;
      end
   endfunction

   // Advance the parse state by one accepted byte and queue the decoded bytes it yields.
   task automatic decode_byte(input logic [7:0] c, input logic last);
      int hi;
      int lo;
      logic is_octal;

      step_bytes.delete();
      is_octal = (c[7:3] == 5'b00110);

      case (dec_mode)
         MODE_ESC: begin
            dec_mode = MODE_IDLE;
            case (c)
               CHAR_BSLASH: step_bytes.push_back(CHAR_BSLASH);
               CHAR_R:      step_bytes.push_back(CODE_CR);
               CHAR_N:      step_bytes.push_back(CODE_LF);
               CHAR_T:      step_bytes.push_back(CODE_HT);
               CHAR_V:      step_bytes.push_back(CODE_VT);
               CHAR_A:      step_bytes.push_back(CODE_BEL);
               CHAR_X:      dec_mode = MODE_HEX1;
               default: begin
                  if (is_octal) begin
                     dec_octal   = {5'd0, c[2:0]};
                     dec_ndigits = 2'd1;
                     dec_mode    = MODE_OCT;
                  end else begin
                     // unknown escape: both bytes go out unchanged
                     step_bytes.push_back(CHAR_BSLASH);
                     step_bytes.push_back(c);
                  end
               end
            endcase
         end
         MODE_OCT: begin
            // a third digit is taken only while the value still fits a byte
            if (is_octal && (dec_ndigits == 2'd1 || (dec_ndigits == 2'd2 && dec_octal < 8'd32)))
            begin
               dec_octal   = {dec_octal[4:0], c[2:0]};
               dec_ndigits = dec_ndigits + 2'd1;
               if (dec_ndigits == 2'd3) begin
                  step_bytes.push_back(dec_octal);
                  dec_octal   = 8'd0;
                  dec_ndigits = 2'd0;
                  dec_mode    = MODE_IDLE;
               end
            end else begin
               step_bytes.push_back(dec_octal);
               dec_octal   = 8'd0;
               dec_ndigits = 2'd0;
               take_plain(c);
            end
         end
         MODE_HEX1: begin
            if (hex_digit_value(c) >= 0) begin
               dec_held = c;
               dec_mode = MODE_HEX2;
            end else begin
               step_bytes.push_back(CHAR_BSLASH);
               step_bytes.push_back(CHAR_X);
               take_plain(c);
            end
         end
         MODE_HEX2: begin
            lo = hex_digit_value(c);
            if (lo >= 0) begin
               hi = hex_digit_value(dec_held);
               step_bytes.push_back(8'(hi * 16 + lo));
               dec_held = 8'd0;
               dec_mode = MODE_IDLE;
            end else begin
               step_bytes.push_back(CHAR_BSLASH);
               step_bytes.push_back(CHAR_X);
               step_bytes.push_back(dec_held);
               dec_held = 8'd0;
               take_plain(c);
            end
         end
         default: take_plain(c);
      endcase

      // End of string: flush whatever escape is still open, then return to idle
      if (last) begin
         case (dec_mode)
            MODE_ESC: step_bytes.push_back(CHAR_BSLASH);
            MODE_OCT: step_bytes.push_back(dec_octal);
            MODE_HEX1: begin
               step_bytes.push_back(CHAR_BSLASH);
               step_bytes.push_back(CHAR_X);
            end
            MODE_HEX2: begin
               step_bytes.push_back(CHAR_BSLASH);
               step_bytes.push_back(CHAR_X);
               step_bytes.push_back(dec_held);
            end
            default: ;
         endcase
         dec_mode    = MODE_IDLE;
         dec_octal   = 8'd0;
         dec_ndigits = 2'd0;
         dec_held    = 8'd0;
      end

      // Only the last byte of a flushing step carries out_end
      foreach (step_bytes[i]) begin
         expected_bytes.push_back('{out_char: step_bytes[i],
                                    out_end:  last && (i == step_bytes.size() - 1)});
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one byte, hold it until the transfer happens, then predict its results.
   // The sender may idle first; valid drops only on a cycle that starts a gap.
   task automatic send_byte(input logic [7:0] c, input logic last);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_char: c, in_end: last};
      // hold the payload until an edge sees valid high and stall low
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      decode_byte(c, last);
   endtask

   // Send a text; the end flag rides on its last byte only when asked.
   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], end_last && (i == s.len() - 1));
      end
   endtask

   // Receiver backpressure: a fresh random stall every cycle at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic set_idling(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // ------------------------------------------------------------------
   // Result checker: compare each transfer with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t ns: unexpected result char=%02h end=%b", $time,
                     rsp_payload.out_char, rsp_payload.out_end);
            mismatch_count++;
         end else begin
            next_expected = expected_bytes.pop_front();
            if (rsp_payload.out_char !== next_expected.out_char) begin
               $display("%0t ns: out_char expected %02h actual %02h", $time,
                        next_expected.out_char, rsp_payload.out_char);
               mismatch_count++;
            end
            if (rsp_payload.out_end !== next_expected.out_end) begin
               $display("%0t ns: out_end expected %b actual %b", $time,
                        next_expected.out_end, rsp_payload.out_end);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Zero byte passes through; an unknown escape with 0xFF keeps both bytes.
   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(CHAR_BSLASH, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   // Every named escape, the escaped backslash included.
   task automatic test_named_escapes();
      send_text("\\r\\n\\t\\v\\a\\\\", 1'b0);
   endtask

   // Full three-digit octal, then one whose first digit refuses a third digit.
   task automatic test_octal_escapes();
      send_text("\\377", 1'b0);
      send_text("\\477", 1'b1);
   endtask

   // Two-digit hex in mixed case; then a broken one cut short by a backslash
   // at end of string, which gives the largest burst of results.
   task automatic test_hex_escapes();
      send_text("\\xfF", 1'b0);
      send_text("\\x4\\", 1'b1);
   endtask

   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
   endfunction

   // Half well-formed escapes with random content; the rest noise, plain text and broken escapes.
   task automatic send_random_token();
      logic [7:0] token[$];
      int kind;
      int ndigits;

      kind = $urandom_range(9);
      case (kind)
         0, 1: token.push_back(8'($urandom_range(255)));
         2: begin
            token.push_back(CHAR_BSLASH);
            token.push_back(named_chars[$urandom_range(5)]);
         end
         3, 4: begin
            ndigits = $urandom_range(1, 3);
            token.push_back(CHAR_BSLASH);
            for (int i = 0; i < ndigits; i++) token.push_back(8'(8'h30 + $urandom_range(7)));
         end
         5, 6: begin
            token.push_back(CHAR_BSLASH);
            token.push_back(CHAR_X);
            token.push_back(random_hex_digit());
            token.push_back(random_hex_digit());
         end
         7: begin
            token.push_back(CHAR_BSLASH);
            token.push_back(CHAR_X);
            if ($urandom_range(1)) token.push_back(random_hex_digit());
            token.push_back(8'($urandom_range(255)));
         end
         8: begin
            token.push_back(CHAR_BSLASH);
            token.push_back(8'($urandom_range(255)));
         end
         default: begin
            ndigits = $urandom_range(1, 4);
            for (int i = 0; i < ndigits; i++) token.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end
      endcase
      // an end flag may land anywhere, also in the middle of an escape
      foreach (token[i]) send_byte(token[i], $urandom_range(9) == 0);
   endtask

   task automatic test_random_stream(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_token();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_plain_bytes();
      test_named_escapes();
      test_octal_escapes();
      test_hex_escapes();

      // random part under each idling pattern
      test_random_stream(60);
      set_idling(62, 0);
      test_random_stream(60);
      set_idling(0, 62);
      test_random_stream(60);
      set_idling(29, 29);
      test_random_stream(60);

      // drop valid so the last byte is not offered again
      req_valid <= 1'b0;

      // wait out every expected result, then keep watching for strays
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
